/* rtl/ctot_pkg.sv */
// Package for the counter-triggered operation table.
// Shared sizes, result codes, table entry layout and controller/datapath structs.
// No dependencies.
package ctot_pkg;

  localparam int TABLE_DEPTH   = 64;
  localparam int COUNTER_COUNT = 64;
  localparam int SLOT_COUNT    = 256;

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

  localparam int CTR_W   = 6;
  localparam int KIND_W  = 3;
  localparam int SLOT_W  = 8;
  localparam int LIMIT_W = 64;
  localparam int STAT_W  = 2;

  localparam logic [KIND_W-1:0] KIND_MAX = 3'd6;

  typedef enum logic [STAT_W-1:0] {
    ST_ARMED    = 2'd0,
    ST_REJECTED = 2'd1,
    ST_FIRED    = 2'd2,
    ST_NONE     = 2'd3
  } status_e;

  typedef enum logic {
    CMD_ARM  = 1'b0,
    CMD_PULL = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [CTR_W-1:0]   counter;
    logic [KIND_W-1:0]  kind;
    logic [SLOT_W-1:0]  slot;
    logic [LIMIT_W-1:0] limit;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller -> datapath
  typedef struct packed {
    logic capture;    // latch accepted transaction, reset scan pointers
    logic arm_done;   // write entry if legal, load arm result
    logic rd_issue;   // read table at scan pointer
    logic eval_keep;  // entry survives: compact it to write pointer
    logic eval_fire;  // entry fires: push previous pending, hold this one
    logic finish;     // emit final result, commit new fill
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic fire;
    logic pend_valid;
    logic out_free;
  } dp_stat_t;

endpackage

/* rtl/ctot_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ctot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/ctot_ctl.sv */
// Controller FSM of the counter-triggered operation table.
// Depends on ctot_pkg (command codes, command/status structs).
module ctot_ctl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                cmd_i,
  input  ctot_pkg::dp_stat_t  stat_i,
  output ctot_pkg::ctl_cmd_t  ctl_o
);
  import ctot_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ARM  = 5'b00010,
    S_RD   = 5'b00100,
    S_EV   = 5'b01000,
    S_END  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctl_o.capture = 1'b1;
          state_d = (cmd_i == CMD_PULL) ? S_RD : S_ARM;
        end
      end
      S_ARM: begin
        if (stat_i.out_free) begin
          ctl_o.arm_done = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_RD: begin
        if (stat_i.scan_done) begin
          state_d = S_END;
        end else begin
          ctl_o.rd_issue = 1'b1;
          state_d = S_EV;
        end
      end
      S_EV: begin
        if (!stat_i.fire) begin
          ctl_o.eval_keep = 1'b1;
          state_d = S_RD;
        end else if (!stat_i.pend_valid || stat_i.out_free) begin
          ctl_o.eval_fire = 1'b1;
          state_d = S_RD;
        end
      end
      S_END: begin
        if (stat_i.out_free) begin
          ctl_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/ctot_dp.sv */
// Datapath of the counter-triggered operation table: table RAM, fill count,
// scan/compaction pointers, pending fired entry and output register.
// Depends on ctot_pkg and ctot_ram.
module ctot_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_i,
  input  logic [ctot_pkg::CTR_W-1:0]    counter_id_i,
  input  logic [ctot_pkg::KIND_W-1:0]   op_kind_i,
  input  logic [ctot_pkg::SLOT_W-1:0]   op_slot_i,
  input  logic [ctot_pkg::LIMIT_W-1:0]  threshold_i,
  input  logic [ctot_pkg::LIMIT_W-1:0]  success_count_i,
  input  ctot_pkg::ctl_cmd_t            ctl_i,
  output ctot_pkg::dp_stat_t            stat_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ctot_pkg::STAT_W-1:0]   status_o,
  output logic [ctot_pkg::KIND_W-1:0]   fired_kind_o,
  output logic [ctot_pkg::SLOT_W-1:0]   fired_slot_o,
  output logic [ctot_pkg::CTR_W-1:0]    fired_counter_o,
  output logic                          last_o
);
  import ctot_pkg::*;

  // latched transaction
  entry_t             req_q;
  logic [LIMIT_W-1:0] cnt_q;
  logic               ctr_ok_q;

  logic [FILL_W-1:0] fill_q, rd_idx_q, wr_ptr_q;
  entry_t            pend_q;
  logic              pend_valid_q;

  logic              out_valid_q, last_q;
  logic [STAT_W-1:0] status_q;
  logic [KIND_W-1:0] kind_q;
  logic [SLOT_W-1:0] slot_q;
  logic [CTR_W-1:0]  ctr_q;

  entry_t            rd_data;
  logic              arm_ok, wr_en, out_free;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;

  assign arm_ok = (fill_q < FILL_W'(TABLE_DEPTH)) &&
                  (32'(req_q.counter) < COUNTER_COUNT) &&
                  (32'(req_q.slot) < SLOT_COUNT) &&
                  (req_q.kind <= KIND_MAX);

  assign out_free = !out_valid_q || !out_stall_i;

  assign stat_o.scan_done  = (rd_idx_q == fill_q) || !ctr_ok_q;
  assign stat_o.fire       = (rd_data.counter == req_q.counter) &&
                             (cnt_q >= rd_data.limit);
  assign stat_o.pend_valid = pend_valid_q;
  assign stat_o.out_free   = out_free;

  // appends go to the fill point, survivors of a scan compact downward
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill_q[ADDR_W-1:0];
    wr_data = req_q;
    if (ctl_i.arm_done && arm_ok) begin
      wr_en = 1'b1;
    end else if (ctl_i.eval_keep) begin
      wr_en   = 1'b1;
      wr_addr = wr_ptr_q[ADDR_W-1:0];
      wr_data = rd_data;
    end
  end

  ctot_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (ctl_i.rd_issue),
    .rd_addr_i (rd_idx_q[ADDR_W-1:0]),
    .rd_data_o (rd_data)
  );

  // transaction payload, no reset
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      req_q.counter <= counter_id_i;
      req_q.kind    <= op_kind_i;
      req_q.slot    <= op_slot_i;
      req_q.limit   <= threshold_i;
      cnt_q         <= success_count_i;
      ctr_ok_q      <= (cmd_i == CMD_PULL) && (32'(counter_id_i) < COUNTER_COUNT);
    end
    if (ctl_i.eval_fire) begin
      pend_q <= rd_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      rd_idx_q     <= '0;
      wr_ptr_q     <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      if (ctl_i.capture) begin
        rd_idx_q     <= '0;
        wr_ptr_q     <= '0;
        pend_valid_q <= 1'b0;
      end
      if (ctl_i.rd_issue) begin
        rd_idx_q <= rd_idx_q + FILL_W'(1);
      end
      if (ctl_i.eval_keep) begin
        wr_ptr_q <= wr_ptr_q + FILL_W'(1);
      end
      if (ctl_i.eval_fire) begin
        pend_valid_q <= 1'b1;
      end
      if (ctl_i.arm_done && arm_ok) begin
        fill_q <= fill_q + FILL_W'(1);
      end
      if (ctl_i.finish) begin
        pend_valid_q <= 1'b0;
        if (ctr_ok_q) begin
          fill_q <= wr_ptr_q;
        end
      end
    end
  end

  // output register
  logic push_pend;
  assign push_pend = ctl_i.eval_fire && pend_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.arm_done || push_pend || ctl_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.arm_done) begin
      status_q <= arm_ok ? ST_ARMED : ST_REJECTED;
      kind_q   <= '0;
      slot_q   <= '0;
      ctr_q    <= '0;
      last_q   <= 1'b1;
    end else if (push_pend || (ctl_i.finish && pend_valid_q)) begin
      status_q <= ST_FIRED;
      kind_q   <= pend_q.kind;
      slot_q   <= pend_q.slot;
      ctr_q    <= pend_q.counter;
      last_q   <= ctl_i.finish;
    end else if (ctl_i.finish) begin
      status_q <= ST_NONE;
      kind_q   <= '0;
      slot_q   <= '0;
      ctr_q    <= '0;
      last_q   <= 1'b1;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign fired_kind_o    = kind_q;
  assign fired_slot_o    = slot_q;
  assign fired_counter_o = ctr_q;
  assign last_o          = last_q;

endmodule

/* rtl/counter_triggered_op_table.sv */
// Top level of the counter-triggered operation table.
// Depends on ctot_pkg, ctot_ctl, ctot_dp (and ctot_ram through ctot_dp).
//
// Holds up to TABLE_DEPTH pending triggered operations in arrival order.
// One transaction is worked on at a time. An arm is latched on acceptance,
// then checked and appended, and returns armed or rejected. A pull is
// latched, then scans and evaluates all the live table
// entries: the scan walks the table RAM one entry per read/evaluate pair,
// set by the single registered read port, while survivors are compacted in
// place through the write port. Each fired entry comes out as one result,
// in arrival order; a fired entry is held one step so that the final one
// can carry last. A pull that fires nothing, or names a counter out of
// range, gives one nothing-fired result. A result waiting in the output
// register does not stop the next transaction from being accepted; the
// scan pauses only when a second result is ready before the first is taken.
// No clearing pass after reset: the table is empty by its fill count.
module counter_triggered_op_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cmd_i,
  input  logic [ctot_pkg::CTR_W-1:0]    counter_id_i,
  input  logic [ctot_pkg::KIND_W-1:0]   op_kind_i,
  input  logic [ctot_pkg::SLOT_W-1:0]   op_slot_i,
  input  logic [ctot_pkg::LIMIT_W-1:0]  threshold_i,
  input  logic [ctot_pkg::LIMIT_W-1:0]  success_count_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ctot_pkg::STAT_W-1:0]   status_o,
  output logic [ctot_pkg::KIND_W-1:0]   fired_kind_o,
  output logic [ctot_pkg::SLOT_W-1:0]   fired_slot_o,
  output logic [ctot_pkg::CTR_W-1:0]    fired_counter_o,
  output logic                          last_o
);
  import ctot_pkg::*;

  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;

  // sequencer: accept, arm check, scan read/evaluate, final result
  ctot_ctl u_ctl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .stat_i     (dp_stat),
    .ctl_o      (ctl_cmd)
  );

  // table storage, pointers and result register
  ctot_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd_i),
    .counter_id_i    (counter_id_i),
    .op_kind_i       (op_kind_i),
    .op_slot_i       (op_slot_i),
    .threshold_i     (threshold_i),
    .success_count_i (success_count_i),
    .ctl_i           (ctl_cmd),
    .stat_o          (dp_stat),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .fired_kind_o    (fired_kind_o),
    .fired_slot_o    (fired_slot_o),
    .fired_counter_o (fired_counter_o),
    .last_o          (last_o)
  );

endmodule

/* rtl/ctot_checker.sv */
// Port-level checker for counter_triggered_op_table, with its bind.
// Depends on ctot_pkg (sizes, result codes).
module ctot_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic [ctot_pkg::STAT_W-1:0]   status_o,
  input  logic [ctot_pkg::KIND_W-1:0]   fired_kind_o,
  input  logic [ctot_pkg::SLOT_W-1:0]   fired_slot_o,
  input  logic [ctot_pkg::CTR_W-1:0]    fired_counter_o,
  input  logic                          last_o
);
  import ctot_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
    $stable(fired_slot_o) && $stable(last_o))
    else $error("stalled result changed");

  // only fired results carry operation fields
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_FIRED) |->
    (fired_kind_o == '0) && (fired_slot_o == '0) && (fired_counter_o == '0))
    else $error("non-fired result with operation fields");

  // armed, rejected and nothing-fired are single results
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_FIRED) |-> last_o)
    else $error("single result without last");

  // one transaction at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction accepted back to back");

endmodule

bind counter_triggered_op_table ctot_checker u_ctot_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .fired_kind_o    (fired_kind_o),
  .fired_slot_o    (fired_slot_o),
  .fired_counter_o (fired_counter_o),
  .last_o          (last_o)
);

/* tb/tb.sv */
// Self-checking testbench for counter_triggered_op_table.
// Depends on ctot_pkg and the RTL; an in-bench table model predicts every result,
// while both handshake sides idle and stall at random.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ctot_pkg::*;

  localparam int HALF_PERIOD  = 4;
  // Longest quiet stretch: receiver hold-off or a full-table scan, plus stalls.
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 200;
  localparam int MAX_REPORTS  = 10;

  localparam logic [KIND_W-1:0] KIND_CTINC       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CTSET       = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PUT         = 3'd2;
  localparam logic [KIND_W-1:0] KIND_GET         = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ATOMIC      = 3'd4;
  localparam logic [KIND_W-1:0] KIND_FETCHATOMIC = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SWAP        = 3'd6;
  localparam logic [KIND_W-1:0] KIND_UNUSED      = 3'd7;

  localparam logic [LIMIT_W-1:0] ALL_ONES = '1;
  localparam logic [LIMIT_W-1:0] MSB_ONLY = {1'b1, {(LIMIT_W-1){1'b0}}};

  typedef struct {
    logic [CTR_W-1:0]   counter;
    logic [KIND_W-1:0]  kind;
    logic [SLOT_W-1:0]  slot;
    logic [LIMIT_W-1:0] limit;
  } armed_op_t;

  typedef struct {
    status_e           status;
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [CTR_W-1:0]  counter;
    logic              last;
  } op_result_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                in_valid_i      = 1'b0;
  logic                in_stall_o;
  logic                cmd_i           = 1'b0;
  logic [CTR_W-1:0]    counter_id_i    = '0;
  logic [KIND_W-1:0]   op_kind_i       = '0;
  logic [SLOT_W-1:0]   op_slot_i       = '0;
  logic [LIMIT_W-1:0]  threshold_i     = '0;
  logic [LIMIT_W-1:0]  success_count_i = '0;
  logic                out_valid_o;
  logic                out_stall_i     = 1'b0;
  logic [STAT_W-1:0]   status_o;
  logic [KIND_W-1:0]   fired_kind_o;
  logic [SLOT_W-1:0]   fired_slot_o;
  logic [CTR_W-1:0]    fired_counter_o;
  logic                last_o;

  armed_op_t  armed_ops[$];         // pending operations, oldest first
  op_result_t expected_results[$];  // results still owed by the block

  int   mismatches   = 0;
  int   idle_cycles  = 0;
  int   burst_left   = 0;
  bit   sender_gaps  = 1'b1;
  logic hold_req     = 1'b0;
  bit   hold_taken   = 1'b0;
  int   hold_left    = 0;
  int   segment_left = 0;
  int   stall_pct    = 0;

  counter_triggered_op_table u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .counter_id_i    (counter_id_i),
    .op_kind_i       (op_kind_i),
    .op_slot_i       (op_slot_i),
    .threshold_i     (threshold_i),
    .success_count_i (success_count_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .fired_kind_o    (fired_kind_o),
    .fired_slot_o    (fired_slot_o),
    .fired_counter_o (fired_counter_o),
    .last_o          (last_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  function automatic logic [LIMIT_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly small thresholds so pulls fire often; now and then full-width values.
  function automatic logic [LIMIT_W-1:0] rand_threshold();
    case ($urandom_range(9, 0))
      0: return rand64();
      1: return ALL_ONES;
      default: return LIMIT_W'($urandom_range(200, 0));
    endcase
  endfunction

  // Updates the table model for one accepted transaction and queues its results.
  task automatic model_transaction(input logic c, input logic [CTR_W-1:0] ctr,
                                   input logic [KIND_W-1:0] kind,
                                   input logic [SLOT_W-1:0] slot,
                                   input logic [LIMIT_W-1:0] thr,
                                   input logic [LIMIT_W-1:0] cnt);
    op_result_t res;
    int idx;
    int fired;
    res.status  = ST_NONE;
    res.kind    = '0;
    res.slot    = '0;
    res.counter = '0;
    res.last    = 1'b1;
    if (c == CMD_ARM) begin
      if (armed_ops.size() >= TABLE_DEPTH || kind > KIND_MAX ||
          ctr >= COUNTER_COUNT || slot >= SLOT_COUNT) begin
        res.status = ST_REJECTED;
      end else begin
        armed_ops.push_back('{counter: ctr, kind: kind, slot: slot, limit: thr});
        res.status = ST_ARMED;
      end
      expected_results.push_back(res);
    end else begin
      fired = 0;
      idx   = 0;
      // Remove every matching entry that reached its threshold, in arrival order.
      while (ctr < COUNTER_COUNT && idx < armed_ops.size()) begin
        if (armed_ops[idx].counter == ctr && cnt >= armed_ops[idx].limit) begin
          res.status  = ST_FIRED;
          res.kind    = armed_ops[idx].kind;
          res.slot    = armed_ops[idx].slot;
          res.counter = armed_ops[idx].counter;
          res.last    = 1'b0;
          expected_results.push_back(res);
          armed_ops.delete(idx);
          fired++;
        end else begin
          idx++;
        end
      end
      if (fired == 0) begin
        expected_results.push_back(res);
      end else begin
        expected_results[expected_results.size()-1].last = 1'b1;
      end
    end
  endtask

  // Both channels are sampled at the edge, before any of this edge's updates land.
  always @(posedge clk_i) begin : scoreboard
    op_result_t exp_res;
    bit took_result;
    bit took_item;
    took_result = rst_ni && out_valid_o && !out_stall_i;
    took_item   = rst_ni && in_valid_i && !in_stall_o;
    if (took_result) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: unexpected result: status %0d kind %0d slot %0d counter %0d last %0d",
                   $realtime, status_o, fired_kind_o, fired_slot_o, fired_counter_o, last_o);
        end
      end else begin
        exp_res = expected_results.pop_front();
        if (status_o !== exp_res.status || fired_kind_o !== exp_res.kind ||
            fired_slot_o !== exp_res.slot || fired_counter_o !== exp_res.counter ||
            last_o !== exp_res.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: mismatch: expected status %0d kind %0d slot %0d counter %0d last %0d",
                     $realtime, exp_res.status, exp_res.kind, exp_res.slot,
                     exp_res.counter, exp_res.last);
            $display("%0t:           got status %0d kind %0d slot %0d counter %0d last %0d",
                     $realtime, status_o, fired_kind_o, fired_slot_o, fired_counter_o, last_o);
          end
        end
      end
    end
    if (took_item) begin
      model_transaction(cmd_i, counter_id_i, op_kind_i, op_slot_i, threshold_i,
                        success_count_i);
    end
    idle_cycles = (took_result || took_item) ? 0 : idle_cycles + 1;
  end

  // Receiver: segments of no, light or heavy stalling, plus a long hold-off on request.
  always @(posedge clk_i) begin : receiver
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end else if (!hold_req) begin
      hold_taken = 1'b0;
    end
    if (segment_left == 0) begin
      segment_left = $urandom_range(64, 16);
      case ($urandom_range(2, 0))
        0: stall_pct = 0;
        1: stall_pct = 25;
        default: stall_pct = 60;
      endcase
    end
    segment_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99, 0) < stall_pct);
    end
  end

  // Offers one transaction and returns at the edge where it is taken.
  // Valid only drops between bursts, so back-to-back items keep it high.
  task automatic send_item(input cmd_e c, input logic [CTR_W-1:0] ctr,
                           input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] slot,
                           input logic [LIMIT_W-1:0] thr, input logic [LIMIT_W-1:0] cnt);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap = (!sender_gaps || $urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i      <= 1'b1;
    cmd_i           <= c;
    counter_id_i    <= ctr;
    op_kind_i       <= kind;
    op_slot_i       <= slot;
    threshold_i     <= thr;
    success_count_i <= cnt;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Unused fields of each command carry random bits; the block must ignore them.
  task automatic arm_op(input logic [CTR_W-1:0] ctr, input logic [KIND_W-1:0] kind,
                        input logic [SLOT_W-1:0] slot, input logic [LIMIT_W-1:0] thr);
    send_item(CMD_ARM, ctr, kind, slot, thr, rand64());
  endtask

  task automatic pull_counter(input logic [CTR_W-1:0] ctr, input logic [LIMIT_W-1:0] cnt);
    send_item(CMD_PULL, ctr, KIND_W'($urandom), SLOT_W'($urandom), rand64(), cnt);
  endtask

  // Every kind, field extremes, the unused kind, duplicate slots, equal thresholds.
  task automatic test_directed_ops();
    pull_counter(6'd0, '0);
    arm_op(6'd0,  KIND_CTINC,       8'd0,   '0);
    arm_op(6'd63, KIND_CTSET,       8'd255, ALL_ONES);
    arm_op(6'd5,  KIND_PUT,         8'd17,  64'd100);
    arm_op(6'd5,  KIND_GET,         8'd17,  64'd50);
    arm_op(6'd5,  KIND_ATOMIC,      8'd200, 64'd100);
    arm_op(6'd0,  KIND_FETCHATOMIC, 8'd128, MSB_ONLY);
    arm_op(6'd0,  KIND_SWAP,        8'd1,   64'd1);
    arm_op(6'd9,  KIND_UNUSED,      8'd3,   '0);
    pull_counter(6'd5,  64'd49);
    pull_counter(6'd5,  64'd100);
    pull_counter(6'd63, ALL_ONES - 64'd1);
    pull_counter(6'd63, ALL_ONES);
    pull_counter(6'd0,  '0);
    pull_counter(6'd0,  MSB_ONLY - 64'd1);
    pull_counter(6'd0,  ALL_ONES);
    pull_counter(6'd0,  ALL_ONES);
    pull_counter(6'd9,  ALL_ONES);
  endtask

  // Receiver holds off while arms keep coming: the block backs up, then the table
  // overflows and the extra arms are rejected.
  task automatic test_table_pressure();
    sender_gaps = 1'b0;
    hold_req <= 1'b1;
    for (int i = 0; i < TABLE_DEPTH + 4; i++) begin
      arm_op(CTR_W'($urandom_range(3, 0)), KIND_W'($urandom_range(6, 0)),
             SLOT_W'($urandom), rand_threshold());
    end
    hold_req <= 1'b0;
    sender_gaps = 1'b1;
  endtask

  // Mixed arms and pulls on a few hot counters, with some noise on the rest.
  task automatic test_random_mix();
    logic [CTR_W-1:0]  ctr;
    logic [KIND_W-1:0] kind;
    logic [LIMIT_W-1:0] cnt;
    for (int i = 0; i < 140; i++) begin
      sender_gaps = ((i / 35) % 2) == 0;
      ctr = ($urandom_range(3, 0) == 0) ? CTR_W'($urandom) : CTR_W'($urandom_range(7, 0));
      if ($urandom_range(99, 0) < 55) begin
        kind = ($urandom_range(19, 0) == 0) ? KIND_UNUSED : KIND_W'($urandom_range(6, 0));
        arm_op(ctr, kind, SLOT_W'($urandom), rand_threshold());
      end else begin
        case ($urandom_range(9, 0))
          0: cnt = rand64();
          1: cnt = ALL_ONES;
          default: cnt = LIMIT_W'($urandom_range(250, 0));
        endcase
        pull_counter(ctr, cnt);
      end
    end
  endtask

  // Watchdog: sampled away from the active edge.
  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(negedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : main
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_ops();
    test_table_pressure();
    test_random_mix();
    in_valid_i <= 1'b0;
    // let the scoreboard queue the last transaction's results first
    @(negedge clk_i);
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/ctot_pkg.sv
rtl/ctot_ram.sv
rtl/ctot_ctl.sv
rtl/ctot_dp.sv
rtl/counter_triggered_op_table.sv
rtl/ctot_checker.sv
tb/tb.sv
